/* rtl/byte_budget_lru_cache_tags_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte budget LRU cache tags block
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_TAGS_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_TAGS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the byte budget LRU cache tags block.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned SIZE_W = 30;
  localparam int unsigned KEY_W  = 16;

  typedef enum logic [1:0] {
    KIND_HIT     = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_NOCACHE = 2'd2,
    KIND_EVICT   = 2'd3
  } result_kind_e;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_SCAN       = 10'b00_0000_0010,
    ST_HIT_OUT    = 10'b00_0000_0100,
    ST_MISS_DEC   = 10'b00_0000_1000,
    ST_EV_RD      = 10'b00_0001_0000,
    ST_EV_OUT     = 10'b00_0010_0000,
    ST_INSERT     = 10'b00_0100_0000,
    ST_SHIFT      = 10'b00_1000_0000,
    ST_SHIFT_LAST = 10'b01_0000_0000,
    ST_WRITE0     = 10'b10_0000_0000
  } state_e;

endpackage

/* rtl/bbc_tag_ram.sv */
// ----------------------------------------------------------------------------
// bbc_tag_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_tag_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 46
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/byte_budget_lru_cache_tags.sv */
// Order: a hit is answered once the scan reaches its recency position; a miss is
// answered with each eviction in turn and then the insertion, or with one no-cache word.
// A new request is taken only in idle, once the scan and the shift of the recency
// ordered entries through the tag RAM for the request in hand are done.
// Reset: the cache is empty, total bytes zero, byte_limit 16777216; RAM contents
// are not cleared, since only data from positions below the entry count is ever used.
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_tags
// Size aware LRU tag bookkeeping; the RAM holds entries in recency order.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_tags #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] key_tag_i,
  input  logic [29:0] object_size_i,
  input  logic        fetch_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] result_tag_o,
  output logic [29:0] result_size_o,
  output logic        last_flag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW     = $clog2(ENTRIES);
  localparam int unsigned CW     = $clog2(ENTRIES + 1);
  localparam int unsigned TAG_W  = (KEY_BITS < bbc_pkg::KEY_W) ? KEY_BITS : bbc_pkg::KEY_W;
  localparam int unsigned WORD_W = TAG_W + bbc_pkg::SIZE_W;
  localparam logic [29:0] LIMIT_RST = 30'd16777216;

  bbc_pkg::state_e state_q, state_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     cmp_addr_q, cmp_addr_d;
  logic [AW-1:0]     hit_addr_q, hit_addr_d;
  logic              sh_vld_q, sh_vld_d;
  logic [AW-1:0]     sh_addr_q, sh_addr_d;
  logic [WORD_W-1:0] new_word_q, new_word_d;
  logic [15:0]       raw_tag_q, raw_tag_d;
  logic [TAG_W-1:0]  mtag_q, mtag_d;
  logic [29:0]       size_q, size_d;
  logic              ok_q, ok_d;
  logic [CW-1:0]     count_q, count_d;
  logic [29:0]       total_q, total_d;
  logic [29:0]       limit_q;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_kind_q, out_kind_d;
  logic [15:0]       out_tag_q, out_tag_d;
  logic [29:0]       out_size_q, out_size_d;
  logic              out_last_q, out_last_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] rdata;
  logic [TAG_W-1:0]  rd_tag;
  logic [29:0]       rd_size;

  logic              out_free;
  logic [CW-1:0]     count_m1;
  logic [AW-1:0]     last_idx;
  logic [30:0]       sum;
  logic              cfg_we;

  bbc_tag_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  assign rd_tag   = rdata[WORD_W-1:bbc_pkg::SIZE_W];
  assign rd_size  = rdata[bbc_pkg::SIZE_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign count_m1 = count_q - CW'(1);
  assign last_idx = count_m1[AW-1:0];
  assign sum      = {1'b0, total_q} + {1'b0, size_q};

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_addr_d  = cmp_addr_q;
    hit_addr_d  = hit_addr_q;
    sh_vld_d    = sh_vld_q;
    sh_addr_d   = sh_addr_q;
    new_word_d  = new_word_q;
    raw_tag_d   = raw_tag_q;
    mtag_d      = mtag_q;
    size_d      = size_q;
    ok_d        = ok_q;
    count_d     = count_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_tag_d   = out_tag_q;
    out_size_d  = out_size_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = new_word_q;
    mem_raddr   = ptr_q[AW-1:0];

    unique case (state_q)
      bbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          raw_tag_d = key_tag_i;
          mtag_d    = key_tag_i[TAG_W-1:0];
          size_d    = object_size_i;
          ok_d      = fetch_ok_i;
          ptr_d     = '0;
          cmp_vld_d = 1'b0;
          state_d   = (count_q == '0) ? bbc_pkg::ST_MISS_DEC : bbc_pkg::ST_SCAN;
        end
      end
      bbc_pkg::ST_SCAN: begin
        // Reads are issued one per cycle; each compare sees the previous read.
        if (ptr_q < count_q) begin
          cmp_vld_d  = 1'b1;
          cmp_addr_d = ptr_q[AW-1:0];
          ptr_d      = ptr_q + CW'(1);
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (rd_tag == mtag_q) begin
            new_word_d = rdata;
            hit_addr_d = cmp_addr_q;
            cmp_vld_d  = 1'b0;
            state_d    = bbc_pkg::ST_HIT_OUT;
          end else if (cmp_addr_q == last_idx) begin
            cmp_vld_d = 1'b0;
            state_d   = bbc_pkg::ST_MISS_DEC;
          end
        end
      end
      bbc_pkg::ST_HIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = bbc_pkg::KIND_HIT;
          out_tag_d   = raw_tag_q;
          out_size_d  = new_word_q[bbc_pkg::SIZE_W-1:0];
          out_last_d  = 1'b1;
          sh_vld_d    = 1'b0;
          if (hit_addr_q == '0) begin
            state_d = bbc_pkg::ST_WRITE0;
          end else begin
            ptr_d   = CW'(hit_addr_q) - CW'(1);
            state_d = bbc_pkg::ST_SHIFT;
          end
        end
      end
      bbc_pkg::ST_MISS_DEC: begin
        if (!ok_q || (size_q > limit_q)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = bbc_pkg::KIND_NOCACHE;
            out_tag_d   = raw_tag_q;
            out_size_d  = '0;
            out_last_d  = 1'b1;
            state_d     = bbc_pkg::ST_IDLE;
          end
        end else if ((count_q != '0) &&
                     ((sum > {1'b0, limit_q}) || (count_q == CW'(ENTRIES)))) begin
          state_d = bbc_pkg::ST_EV_RD;
        end else begin
          state_d = bbc_pkg::ST_INSERT;
        end
      end
      bbc_pkg::ST_EV_RD: begin
        mem_raddr = last_idx;
        state_d   = bbc_pkg::ST_EV_OUT;
      end
      bbc_pkg::ST_EV_OUT: begin
        // Keep reading the tail so the read data holds while the output stalls.
        mem_raddr = last_idx;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = bbc_pkg::KIND_EVICT;
          out_tag_d   = 16'(rd_tag);
          out_size_d  = rd_size;
          out_last_d  = 1'b0;
          total_d     = total_q - rd_size;
          count_d     = count_m1;
          state_d     = bbc_pkg::ST_MISS_DEC;
        end
      end
      bbc_pkg::ST_INSERT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = bbc_pkg::KIND_INSERT;
          out_tag_d   = raw_tag_q;
          out_size_d  = size_q;
          out_last_d  = 1'b1;
          new_word_d  = {mtag_q, size_q};
          total_d     = total_q + size_q;
          count_d     = count_q + CW'(1);
          sh_vld_d    = 1'b0;
          if (count_q == '0) begin
            state_d = bbc_pkg::ST_WRITE0;
          end else begin
            ptr_d   = count_m1;
            state_d = bbc_pkg::ST_SHIFT;
          end
        end
      end
      bbc_pkg::ST_SHIFT: begin
        // Move entries one position older, from the oldest moved entry down.
        mem_raddr = ptr_q[AW-1:0];
        sh_vld_d  = 1'b1;
        sh_addr_d = ptr_q[AW-1:0];
        if (sh_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = sh_addr_q + AW'(1);
          mem_wdata = rdata;
        end
        if (ptr_q == '0) begin
          state_d = bbc_pkg::ST_SHIFT_LAST;
        end else begin
          ptr_d = ptr_q - CW'(1);
        end
      end
      bbc_pkg::ST_SHIFT_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = sh_addr_q + AW'(1);
        mem_wdata = rdata;
        sh_vld_d  = 1'b0;
        state_d   = bbc_pkg::ST_WRITE0;
      end
      bbc_pkg::ST_WRITE0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_word_q;
        state_d   = bbc_pkg::ST_IDLE;
      end
      default: begin
        state_d = bbc_pkg::ST_IDLE;
      end
    endcase
  end

  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbc_pkg::ST_IDLE;
      cmp_vld_q   <= 1'b0;
      sh_vld_q    <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      limit_q     <= LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      sh_vld_q    <= sh_vld_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        limit_q <= pwdata[29:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    cmp_addr_q <= cmp_addr_d;
    hit_addr_q <= hit_addr_d;
    sh_addr_q  <= sh_addr_d;
    new_word_q <= new_word_d;
    raw_tag_q  <= raw_tag_d;
    mtag_q     <= mtag_d;
    size_q     <= size_d;
    ok_q       <= ok_d;
    out_kind_q <= out_kind_d;
    out_tag_q  <= out_tag_d;
    out_size_q <= out_size_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o    = (state_q == bbc_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign result_tag_o  = out_tag_q;
  assign result_size_o = out_size_q;
  assign last_flag_o   = out_last_q;
  assign prdata        = (paddr[2] == 1'b0) ? {2'b00, limit_q} : 32'd0;
  assign pready        = 1'b1;

endmodule

/* rtl/bbc_checker.sv */
// ----------------------------------------------------------------------------
// bbc_checker
// Port level checks of the byte budget LRU cache tags block.
// ----------------------------------------------------------------------------
`include "byte_budget_lru_cache_tags_macros.svh"

module bbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [29:0] result_size_o,
  input logic        last_flag_o
);

  // A result word waiting on the consumer is not withdrawn.
  `BBC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result word dropped")

  // Only evictions are followed by further words of the same request.
  `BBC_ASSERT_IMP(a_last_kind, out_valid_o,
    last_flag_o == (result_kind_o != bbc_pkg::KIND_EVICT), "last flag does not match kind")

  `BBC_ASSERT_IMP(a_nocache_size, out_valid_o && (result_kind_o == bbc_pkg::KIND_NOCACHE),
    result_size_o == 30'd0, "uncached miss reports nonzero size")

  // The block works on one request at a time.
  `BBC_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

endmodule

bind byte_budget_lru_cache_tags bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_kind_o(result_kind_o),
  .result_size_o(result_size_o),
  .last_flag_o  (last_flag_o)
);
